FILE: rtl/crhh_pkg.sv
// ----------------------------------------------------------------------------
// crhh_pkg: shared types and constants for convex_region_hit_and_height
// Sizes, item mode codes, config register indexes, edge entry layout, FSM.
// ----------------------------------------------------------------------------
`default_nettype none
package crhh_pkg;

  localparam int MAX_REGIONS = 8;
  localparam int MAX_EDGES   = 8;
  localparam int REGION_W    = $clog2(MAX_REGIONS);
  localparam int EDGE_W      = $clog2(MAX_EDGES);
  localparam int EDGE_ADDR_W = REGION_W + EDGE_W;
  localparam int EDGE_DEPTH  = MAX_REGIONS * MAX_EDGES;

  localparam logic [1:0] MODE_EDGE   = 2'd0;
  localparam logic [1:0] MODE_HEADER = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [1:0] CFG_HALF_X  = 2'd0;
  localparam logic [1:0] CFG_HALF_Y  = 2'd1;
  localparam logic [1:0] CFG_REGIONS = 2'd2;
  localparam logic [1:0] CFG_NONE    = 2'd3;

  localparam logic signed [44:0] HV_MAX = {1'b0, {44{1'b1}}};
  localparam logic signed [44:0] HV_MIN = {1'b1, {44{1'b0}}};

  typedef struct packed {
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } edge_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_H4,
    ST_H5,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/convex_region_hit_and_height.sv
// A query searches regions in order, one edge memory read per cycle, then runs the
// height multiply chain on a hit with a height plane; out_ready can hold a result
// back. One in work at a time.
// Reset: config returns to full extents and no regions; edge counts and
// height-plane flags clear; edge memory and height data are undefined.
// ----------------------------------------------------------------------------
// convex_region_hit_and_height
// Region table with per-edge half-plane test and sloped height evaluation.
// ----------------------------------------------------------------------------
`default_nettype none
module convex_region_hit_and_height (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic [2:0]         in_region_slot,
  input  wire logic [2:0]         in_edge_slot,
  input  wire logic [3:0]         in_edge_total,
  input  wire logic signed [23:0] in_coord_x,
  input  wire logic signed [23:0] in_coord_y,
  input  wire logic signed [15:0] in_dir_x,
  input  wire logic signed [15:0] in_dir_y,
  input  wire logic signed [15:0] in_base_level,
  input  wire logic signed [15:0] in_slope_scale,
  input  wire logic               in_height_present,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_inside_res,
  output logic [2:0]              out_hit_slot,
  output logic                    out_height_valid,
  output logic signed [44:0]      out_height_value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_data
);

  localparam int RW = crhh_pkg::REGION_W;

  // config
  logic [14:0] half_x_r, half_y_r;
  logic [3:0]  regions_r;

  // region headers
  logic [3:0]         cnt_r     [crhh_pkg::MAX_REGIONS];
  logic               present_r [crhh_pkg::MAX_REGIONS];
  logic signed [23:0] refx_r    [crhh_pkg::MAX_REGIONS];
  logic signed [23:0] refy_r    [crhh_pkg::MAX_REGIONS];
  logic signed [15:0] sdx_r     [crhh_pkg::MAX_REGIONS];
  logic signed [15:0] sdy_r     [crhh_pkg::MAX_REGIONS];
  logic signed [15:0] base_r    [crhh_pkg::MAX_REGIONS];
  logic signed [15:0] scale_r   [crhh_pkg::MAX_REGIONS];

  // edge memory
  crhh_pkg::edge_entry_t edge_mem [crhh_pkg::EDGE_DEPTH];
  crhh_pkg::edge_entry_t mem_q;

  crhh_pkg::state_t state_r, state_nxt;

  logic signed [23:0] px_r, py_r;
  logic [3:0]         r_r, e_r;
  logic [3:0]         limit;
  logic               reject_r, s1_v_r, s2_v_r;
  logic signed [40:0] ex_prod_r, ey_prod_r;
  logic               issue, region_done, last_region;
  logic               in_acc, query_acc, bound_ok, out_load;
  logic [24:0]        ax, ay;
  logic signed [41:0] edge_sum;

  logic               inside_q, hv_q;
  logic [RW-1:0]      hit_q;
  logic signed [44:0] hval_q;
  logic signed [40:0] hx_prod_r, hy_prod_r;
  logic signed [41:0] dist_r;
  logic signed [37:0] pl_r;
  logic signed [36:0] ph_r;
  logic signed [57:0] prod_r;
  logic signed [46:0] hsum;

  logic signed [24:0] ex, ey, hdx, hdy;

  assign cfg_ready = rst_n;
  assign limit     = (regions_r > 4'(crhh_pkg::MAX_REGIONS)) ?
                     4'(crhh_pkg::MAX_REGIONS) : regions_r;
  assign in_acc    = in_valid && in_ready;
  assign query_acc = in_acc && (in_mode == crhh_pkg::MODE_QUERY);

  assign ax = in_coord_x[23] ? 25'sd0 - 25'(in_coord_x) : 25'(in_coord_x);
  assign ay = in_coord_y[23] ? 25'sd0 - 25'(in_coord_y) : 25'(in_coord_y);
  assign bound_ok = (ax <= {2'b00, half_x_r, 8'h00}) && (ay <= {2'b00, half_y_r, 8'h00});

  assign last_region = (r_r + 4'd1) >= limit;
  assign ex = 25'(px_r) - 25'(mem_q.vx);
  assign ey = 25'(py_r) - 25'(mem_q.vy);
  assign edge_sum = 42'(ex_prod_r) + 42'(ey_prod_r);
  assign hdx = 25'(refx_r[hit_q]) - 25'(px_r);
  assign hdy = 25'(refy_r[hit_q]) - 25'(py_r);
  assign hsum = 47'($signed(prod_r[57:12])) + 47'($signed({base_r[hit_q], 8'h00}));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crhh_pkg::ST_IDLE: begin
        if (query_acc) begin
          state_nxt = (bound_ok && limit != 4'd0) ? crhh_pkg::ST_SCAN : crhh_pkg::ST_DONE;
        end
      end
      crhh_pkg::ST_SCAN: begin
        if (region_done) begin
          if (!reject_r) begin
            state_nxt = present_r[r_r[RW-1:0]] ? crhh_pkg::ST_H1 : crhh_pkg::ST_DONE;
          end else if (last_region) begin
            state_nxt = crhh_pkg::ST_DONE;
          end
        end
      end
      crhh_pkg::ST_H1: state_nxt = crhh_pkg::ST_H2;
      crhh_pkg::ST_H2: state_nxt = crhh_pkg::ST_H3;
      crhh_pkg::ST_H3: state_nxt = crhh_pkg::ST_H4;
      crhh_pkg::ST_H4: state_nxt = crhh_pkg::ST_H5;
      crhh_pkg::ST_H5: state_nxt = crhh_pkg::ST_DONE;
      crhh_pkg::ST_DONE: begin
        if (out_load) state_nxt = crhh_pkg::ST_IDLE;
      end
      default: state_nxt = crhh_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = 1'b0;
    issue       = 1'b0;
    region_done = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      crhh_pkg::ST_IDLE: in_ready = rst_n;
      crhh_pkg::ST_SCAN: begin
        issue       = e_r < cnt_r[r_r[RW-1:0]];
        region_done = !issue && !s1_v_r && !s2_v_r;
      end
      crhh_pkg::ST_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= crhh_pkg::ST_IDLE;
      half_x_r <= 15'h7fff;
      half_y_r <= 15'h7fff;
      regions_r <= 4'd0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < crhh_pkg::MAX_REGIONS; i++) begin
        cnt_r[i]     <= 4'd0;
        present_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      if (cfg_valid) begin
        case (cfg_index)
          crhh_pkg::CFG_HALF_X:  half_x_r  <= cfg_data;
          crhh_pkg::CFG_HALF_Y:  half_y_r  <= cfg_data;
          crhh_pkg::CFG_REGIONS: regions_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_acc && in_mode == crhh_pkg::MODE_HEADER) begin
        cnt_r[in_region_slot] <= (in_edge_total > 4'(crhh_pkg::MAX_EDGES)) ?
                                 4'(crhh_pkg::MAX_EDGES) : in_edge_total;
        present_r[in_region_slot] <= in_height_present;
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // header payload
  always_ff @(posedge clk) begin
    if (in_acc && in_mode == crhh_pkg::MODE_HEADER) begin
      refx_r[in_region_slot]  <= in_coord_x;
      refy_r[in_region_slot]  <= in_coord_y;
      sdx_r[in_region_slot]   <= in_dir_x;
      sdy_r[in_region_slot]   <= in_dir_y;
      base_r[in_region_slot]  <= in_base_level;
      scale_r[in_region_slot] <= in_slope_scale;
    end
  end

  // edge memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && in_mode == crhh_pkg::MODE_EDGE) begin
      edge_mem[{in_region_slot, in_edge_slot}] <= '{vx: in_coord_x, vy: in_coord_y,
                                                    nx: in_dir_x, ny: in_dir_y};
    end
    if (issue) mem_q <= edge_mem[{r_r[RW-1:0], e_r[crhh_pkg::EDGE_W-1:0]}];
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (query_acc) begin
      px_r     <= in_coord_x;
      py_r     <= in_coord_y;
      r_r      <= 4'd0;
      e_r      <= 4'd0;
      reject_r <= 1'b0;
      inside_q <= 1'b0;
      hit_q    <= '0;
      hv_q     <= 1'b0;
      hval_q   <= '0;
    end
    if (issue) e_r <= e_r + 4'd1;
    ex_prod_r <= ex * mem_q.nx;
    ey_prod_r <= ey * mem_q.ny;
    if (s2_v_r && edge_sum > 42'sd0) reject_r <= 1'b1;
    if (region_done) begin
      if (!reject_r) begin
        inside_q <= 1'b1;
        hit_q    <= r_r[RW-1:0];
        hv_q     <= present_r[r_r[RW-1:0]];
      end else if (!last_region) begin
        r_r      <= r_r + 4'd1;
        e_r      <= 4'd0;
        reject_r <= 1'b0;
      end
    end
    // height: dist = d . (ref - p), then dist * scale split in two partials
    hx_prod_r <= sdx_r[hit_q] * hdx;
    hy_prod_r <= sdy_r[hit_q] * hdy;
    if (state_r == crhh_pkg::ST_H2) dist_r <= 42'(hx_prod_r) + 42'(hy_prod_r);
    if (state_r == crhh_pkg::ST_H3) begin
      pl_r <= $signed({1'b0, dist_r[20:0]}) * scale_r[hit_q];
      ph_r <= $signed(dist_r[41:21]) * scale_r[hit_q];
    end
    if (state_r == crhh_pkg::ST_H4) prod_r <= (58'(ph_r) <<< 21) + 58'(pl_r);
    if (state_r == crhh_pkg::ST_H5) begin
      if (hsum > 47'(crhh_pkg::HV_MAX)) hval_q <= crhh_pkg::HV_MAX;
      else if (hsum < 47'(crhh_pkg::HV_MIN)) hval_q <= crhh_pkg::HV_MIN;
      else hval_q <= hsum[44:0];
    end
    if (out_load) begin
      out_inside_res   <= inside_q;
      out_hit_slot     <= 3'(hit_q);
      out_height_valid <= hv_q;
      out_height_value <= hval_q;
    end
  end

endmodule
`default_nettype wire

FILE: test/convex_region_hit_and_height_test.sv
// ----------------------------------------------------------------------------
// convex_region_hit_and_height_test
// Loads convex regions with edge and header transactions, then runs point
// queries. Each accepted query is predicted in the testbench and compared
// field by field with the block's answer, with random bursts and stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module convex_region_hit_and_height_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 120;

  typedef struct {
    logic [1:0]         mode;
    logic [2:0]         rslot;
    logic [2:0]         eslot;
    logic [3:0]         etotal;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] base;
    logic signed [15:0] scale;
    logic               hp;
  } region_item_t;

  typedef struct {
    logic               in_region;
    logic [2:0]         slot;
    logic               hvalid;
    logic signed [44:0] hval;
  } hit_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = '0;
  logic [2:0] in_region_slot = '0;
  logic [2:0] in_edge_slot = '0;
  logic [3:0] in_edge_total = '0;
  logic signed [23:0] in_coord_x = '0;
  logic signed [23:0] in_coord_y = '0;
  logic signed [15:0] in_dir_x = '0;
  logic signed [15:0] in_dir_y = '0;
  logic signed [15:0] in_base_level = '0;
  logic signed [15:0] in_slope_scale = '0;
  logic in_height_present = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_inside_res;
  logic [2:0] out_hit_slot;
  logic out_height_valid;
  logic signed [44:0] out_height_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;

  always #5 clk = ~clk;

  convex_region_hit_and_height i_dut (.*);

  // predictor state
  logic [14:0] pr_half_x = 15'h7fff;
  logic [14:0] pr_half_y = 15'h7fff;
  logic [3:0]  pr_regions = '0;
  logic signed [23:0] pr_vx [crhh_pkg::EDGE_DEPTH];
  logic signed [23:0] pr_vy [crhh_pkg::EDGE_DEPTH];
  logic signed [15:0] pr_nx [crhh_pkg::EDGE_DEPTH];
  logic signed [15:0] pr_ny [crhh_pkg::EDGE_DEPTH];
  logic [3:0]         pr_count [crhh_pkg::MAX_REGIONS] = '{default: '0};
  logic signed [23:0] pr_refx [crhh_pkg::MAX_REGIONS];
  logic signed [23:0] pr_refy [crhh_pkg::MAX_REGIONS];
  logic signed [15:0] pr_sdx [crhh_pkg::MAX_REGIONS];
  logic signed [15:0] pr_sdy [crhh_pkg::MAX_REGIONS];
  logic signed [15:0] pr_base [crhh_pkg::MAX_REGIONS];
  logic signed [15:0] pr_scale [crhh_pkg::MAX_REGIONS];
  logic               pr_present [crhh_pkg::MAX_REGIONS] = '{default: 1'b0};

  hit_answer_t  expected_answers[$];
  region_item_t pending_items[$];
  int errors = 0;
  int cycles = 0;

  // stimulus-side bookkeeping so no unwritten edge is ever read
  bit  edge_loaded [crhh_pkg::EDGE_DEPTH] = '{default: 1'b0};
  int  region_cx [crhh_pkg::MAX_REGIONS] = '{default: 0};
  int  region_cy [crhh_pkg::MAX_REGIONS] = '{default: 0};
  int  region_rad [crhh_pkg::MAX_REGIONS] = '{default: 2560};
  int  oct_dx [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
  int  oct_dy [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

  function automatic bit region_holds(int r, longint px, longint py);
    longint d;
    int idx;
    for (int e = 0; e < pr_count[r] && e < crhh_pkg::MAX_EDGES; e++) begin
      idx = r * crhh_pkg::MAX_EDGES + e;
      d = (px - longint'(pr_vx[idx])) * longint'(pr_nx[idx])
        + (py - longint'(pr_vy[idx])) * longint'(pr_ny[idx]);
      if (d > 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic apply_transaction(region_item_t it);
    hit_answer_t ans;
    longint ax, ay, hv, dist_v;
    int lim, idx;
    case (it.mode)
      crhh_pkg::MODE_EDGE: begin
        idx = it.rslot * crhh_pkg::MAX_EDGES + it.eslot;
        pr_vx[idx] = it.cx; pr_vy[idx] = it.cy;
        pr_nx[idx] = it.dx; pr_ny[idx] = it.dy;
      end
      crhh_pkg::MODE_HEADER: begin
        pr_count[it.rslot] = (it.etotal > crhh_pkg::MAX_EDGES) ?
                             4'(crhh_pkg::MAX_EDGES) : it.etotal;
        pr_refx[it.rslot] = it.cx; pr_refy[it.rslot] = it.cy;
        pr_sdx[it.rslot] = it.dx; pr_sdy[it.rslot] = it.dy;
        pr_base[it.rslot] = it.base; pr_scale[it.rslot] = it.scale;
        pr_present[it.rslot] = it.hp;
      end
      crhh_pkg::MODE_QUERY: begin
        ans = '{1'b0, 3'd0, 1'b0, 45'sd0};
        ax = (it.cx < 0) ? -longint'(it.cx) : longint'(it.cx);
        ay = (it.cy < 0) ? -longint'(it.cy) : longint'(it.cy);
        lim = (pr_regions > crhh_pkg::MAX_REGIONS) ? crhh_pkg::MAX_REGIONS : pr_regions;
        if (ax <= longint'(pr_half_x) * 256 && ay <= longint'(pr_half_y) * 256) begin
          for (int r = 0; r < lim; r++) begin
            if (region_holds(r, it.cx, it.cy)) begin
              ans.in_region = 1'b1;
              ans.slot = 3'(r);
              break;
            end
          end
        end
        if (ans.in_region && pr_present[ans.slot]) begin
          ans.hvalid = 1'b1;
          hv = longint'(pr_base[ans.slot]) * 256;
          if (pr_sdx[ans.slot] != 0 || pr_sdy[ans.slot] != 0) begin
            dist_v = longint'(pr_sdx[ans.slot]) * (longint'(pr_refx[ans.slot]) - it.cx)
                   + longint'(pr_sdy[ans.slot]) * (longint'(pr_refy[ans.slot]) - it.cy);
            hv += (dist_v * longint'(pr_scale[ans.slot])) >>> 12;
          end
          if (hv > longint'(crhh_pkg::HV_MAX)) hv = longint'(crhh_pkg::HV_MAX);
          if (hv < longint'(crhh_pkg::HV_MIN)) hv = longint'(crhh_pkg::HV_MIN);
          ans.hval = 45'(hv);
        end
        expected_answers.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // input acceptance -> predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      apply_transaction('{in_mode, in_region_slot, in_edge_slot, in_edge_total,
                          in_coord_x, in_coord_y, in_dir_x, in_dir_y, in_base_level,
                          in_slope_scale, in_height_present});
  end

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    region_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_mode <= it.mode; in_region_slot <= it.rslot; in_edge_slot <= it.eslot;
        in_edge_total <= it.etotal; in_coord_x <= it.cx; in_coord_y <= it.cy;
        in_dir_x <= it.dx; in_dir_y <= it.dy; in_base_level <= it.base;
        in_slope_scale <= it.scale; in_height_present <= it.hp;
        in_valid <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    hit_answer_t ex;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("convex_region_hit_and_height_test NOT OK");
      $finish;
    end else begin
      if (rst_n && out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          errors++;
          $display("%0t: result transaction with nothing expected", $realtime);
        end else begin
          ex = expected_answers.pop_front();
          if (out_inside_res !== ex.in_region) begin
            errors++;
            $display("%0t: inside_res exp %0b got %0b", $realtime, ex.in_region,
                     out_inside_res);
          end
          if (out_hit_slot !== ex.slot) begin
            errors++;
            $display("%0t: hit_slot exp %0d got %0d", $realtime, ex.slot, out_hit_slot);
          end
          if (out_height_valid !== ex.hvalid) begin
            errors++;
            $display("%0t: height_valid exp %0b got %0b", $realtime, ex.hvalid,
                     out_height_valid);
          end
          if (out_height_value !== ex.hval) begin
            errors++;
            $display("%0t: height_value exp %0d got %0d", $realtime, ex.hval,
                     out_height_value);
          end
        end
      end
      if (cycles % 128 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  function automatic int rand_signed(int w);
    return int'($urandom) >>> (32 - w);
  endfunction

  function automatic region_item_t noise_item(logic [1:0] mode);
    region_item_t it;
    it = '{mode, 3'($urandom), 3'($urandom), 4'($urandom), 24'($urandom), 24'($urandom),
           16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)};
    return it;
  endfunction

  task automatic load_edge(int r, int e, int vx, int vy, int nx, int ny);
    region_item_t it;
    it = noise_item(crhh_pkg::MODE_EDGE);
    it.rslot = 3'(r); it.eslot = 3'(e);
    it.cx = 24'(vx); it.cy = 24'(vy); it.dx = 16'(nx); it.dy = 16'(ny);
    edge_loaded[r * crhh_pkg::MAX_EDGES + e] = 1'b1;
    pending_items.push_back(it);
  endtask

  // random edges for any slot a header would make visible
  task automatic cover_edges(int r, int total);
    int n;
    n = (total > crhh_pkg::MAX_EDGES) ? crhh_pkg::MAX_EDGES : total;
    for (int e = 0; e < n; e++)
      if (!edge_loaded[r * crhh_pkg::MAX_EDGES + e])
        load_edge(r, e, rand_signed(24), rand_signed(24), rand_signed(16), rand_signed(16));
  endtask

  task automatic load_header(int r, int total, int rx, int ry, int sx, int sy,
                             int base, int scale, bit hp);
    region_item_t it;
    cover_edges(r, total);
    it = noise_item(crhh_pkg::MODE_HEADER);
    it.rslot = 3'(r); it.etotal = 4'(total);
    it.cx = 24'(rx); it.cy = 24'(ry); it.dx = 16'(sx); it.dy = 16'(sy);
    it.base = 16'(base); it.scale = 16'(scale); it.hp = hp;
    pending_items.push_back(it);
  endtask

  task automatic query_at(int x, int y);
    region_item_t it;
    it = noise_item(crhh_pkg::MODE_QUERY);
    it.cx = 24'(x); it.cy = 24'(y);
    pending_items.push_back(it);
  endtask

  // well-formed octagon-ish region around a random center
  task automatic build_region(int r);
    int k, j, m, rad, ccx, ccy, sx, sy;
    k = $urandom_range(3, crhh_pkg::MAX_EDGES);
    rad = $urandom_range(1, 1000000);
    ccx = rand_signed(22);
    ccy = rand_signed(22);
    region_cx[r] = ccx; region_cy[r] = ccy; region_rad[r] = rad;
    for (int e = 0; e < k; e++) begin
      j = e * 8 / k;
      m = $urandom_range(1, 32767);
      load_edge(r, e, ccx + oct_dx[j] * rad, ccy + oct_dy[j] * rad,
                oct_dx[j] * m, oct_dy[j] * m);
    end
    sx = ($urandom_range(0, 4) == 0) ? 0 : rand_signed(16);
    sy = ($urandom_range(0, 4) == 0) ? 0 : rand_signed(16);
    load_header(r, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : k,
                rand_signed(24), rand_signed(24), sx, sy, rand_signed(16), rand_signed(16),
                $urandom_range(0, 3) != 0);
  endtask

  task automatic write_register(logic [1:0] idx, logic [14:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      crhh_pkg::CFG_HALF_X:  pr_half_x = data;
      crhh_pkg::CFG_HALF_Y:  pr_half_y = data;
      crhh_pkg::CFG_REGIONS: pr_regions = data[3:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_valid || expected_answers.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(int n_items);
    int n, c, r, q;
    n = 0;
    while (n < n_items) begin
      c = $urandom_range(0, 99);
      r = $urandom_range(0, crhh_pkg::MAX_REGIONS - 1);
      q = pending_items.size();
      if (c < 12) begin
        build_region(r);
      end else if (c < 72) begin
        query_at(region_cx[r] + $urandom_range(0, 3 * region_rad[r]) - 3 * region_rad[r] / 2,
                 region_cy[r] + $urandom_range(0, 3 * region_rad[r]) - 3 * region_rad[r] / 2);
      end else if (c < 78) begin
        query_at(region_cx[r] + region_rad[r], region_cy[r]);
      end else if (c < 88) begin
        query_at(rand_signed(24), rand_signed(24));
      end else if (c < 93) begin
        load_edge(r, $urandom_range(0, 7), rand_signed(24), rand_signed(24),
                  rand_signed(16), rand_signed(16));
      end else if (c < 97) begin
        load_header(r, $urandom_range(0, 15), rand_signed(24), rand_signed(24),
                    rand_signed(16), rand_signed(16), rand_signed(16), rand_signed(16),
                    $urandom_range(0, 1));
      end else begin
        pending_items.push_back(noise_item(crhh_pkg::MODE_NONE));
      end
      n += pending_items.size() - q;
    end
  endtask

  initial begin
    region_item_t it;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // no regions searched yet
    load_header(0, 0, -8388608, 8388607, -32768, -32768, 32767, -32768, 1'b1);
    query_at(0, 0);
    it = noise_item(crhh_pkg::MODE_NONE);
    pending_items.push_back(it);
    drain();

    write_register(crhh_pkg::CFG_REGIONS, 15'd1);
    // empty region: height extremes, bounding reject
    query_at(-8388352, -8388352);
    query_at(8388352, 8388352);
    query_at(8388607, 0);
    query_at(0, -8388608);
    load_header(0, 0, 0, 0, 0, 0, -32768, 32767, 1'b1);
    query_at(1000, -1000);
    load_header(0, 0, 5, 5, 7, 7, 100, 100, 1'b0);
    query_at(3, 4);
    drain();

    write_register(crhh_pkg::CFG_REGIONS, 15'h7fff);
    // square around the origin, on-edge and just outside
    load_edge(1, 0, 2560, 0, 1, 0);
    load_edge(1, 1, 0, 2560, 0, 1);
    load_edge(1, 2, -2560, 0, -1, 0);
    load_edge(1, 3, 0, -2560, 0, -1);
    load_header(1, 4, 0, 0, 1, -1, 10, 4096, 1'b1);
    load_header(0, 15, 0, 0, 0, 0, 0, 0, 1'b1);
    load_edge(2, 0, 100, 100, 0, 0);
    load_header(2, 1, 0, 0, 1, -1, -5, 4095, 1'b1);
    query_at(0, 0);
    query_at(2560, 0);
    query_at(2561, 0);
    drain();

    write_register(crhh_pkg::CFG_HALF_X, 15'd0);
    write_register(crhh_pkg::CFG_HALF_Y, 15'd0);
    query_at(0, 0);
    query_at(1, 0);
    query_at(0, -1);
    drain();

    write_register(crhh_pkg::CFG_NONE, 15'h7fff);
    write_register(crhh_pkg::CFG_HALF_X, 15'h7fff);
    write_register(crhh_pkg::CFG_HALF_Y, 15'h7fff);
    for (int p = 0; p < 6; p++) begin
      random_phase(70);
      drain();
      write_register(crhh_pkg::CFG_REGIONS,
                     (p == 2) ? 15'd0 : 15'($urandom_range(1, 15)));
      write_register(crhh_pkg::CFG_HALF_X, (p == 1) ? 15'd0 : 15'($urandom));
      write_register(crhh_pkg::CFG_HALF_Y, (p % 2 == 0) ? 15'h7fff : 15'($urandom));
    end
    write_register(crhh_pkg::CFG_REGIONS, 15'd8);
    random_phase(40);
    drain();

    if (errors == 0)
      $display("convex_region_hit_and_height_test OK");
    else
      $display("convex_region_hit_and_height_test NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/crhh_pkg.sv
rtl/convex_region_hit_and_height.sv
test/convex_region_hit_and_height_test.sv
